### rtl/core/worker_pool_load_balancer_assert.svh
// assertion macros for the worker pool load balancer
// each macro expects aclk and aresetn in scope at the point of use
`ifndef WORKER_POOL_LOAD_BALANCER_ASSERT_SVH
`define WORKER_POOL_LOAD_BALANCER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WPLB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPLB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WPLB_ASSERT_IMP(lbl, ante, cons, msg)
`define WPLB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/wplb_pkg.sv
package wplb_pkg;

    // default sizes
    localparam int MAX_WORKERS_DEF  = 16;
    localparam int LOAD_WIDTH_DEF   = 16;

    // fallback values for zero register settings
    localparam int DEFAULT_POOL     = 10;
    localparam int DEFAULT_CAPACITY = 1000;

    // field widths
    localparam int OP_W       = 2;
    localparam int ID_W       = 4;
    localparam int STATUS_W   = 3;
    localparam int OUT_LOAD_W = 16;
    localparam int POOL_W     = 5;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [31:0] OUT_LOAD_MAX = 32'h0000_FFFF;

    // operating modes
    localparam logic MODE_FIXED    = 1'b0;
    localparam logic MODE_CAPACITY = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_GRANTED  = 3'd0,
        STS_RELEASED = 3'd1,
        STS_RETIRED  = 3'd2,
        STS_FULL     = 3'd3,
        STS_INVALID  = 3'd4,
        STS_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_POOL_SIZE = 2'd1,
        REG_CAPACITY  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BUILD,
        S_SCAN,
        S_DRAIN,
        S_REL_RD,
        S_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic build;
        logic scan_init;
        logic scan_step;
        logic rel_read;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rel_bad;
        logic            pool_ready;
        logic            scan_last;
        logic            out_free;
    } sts_t;

endpackage

### rtl/core/wplb_ram.sv
module wplb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/wplb_ctrl.sv
module wplb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output wplb_pkg::cmd_t cmd,
    input  wplb_pkg::sts_t sts
);

    import wplb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (op_t'(sts.op))
                    OP_ACQUIRE: state_next = sts.pool_ready ? S_SCAN : S_BUILD;
                    OP_RELEASE: state_next = sts.rel_bad ? S_COMMIT : S_REL_RD;
                    OP_CLEAR:   state_next = S_COMMIT;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_BUILD: state_next = S_SCAN;
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_COMMIT;
            S_REL_RD: state_next = S_COMMIT;
            S_COMMIT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_DECODE: cmd.scan_init = 1'b1;
            S_BUILD:  cmd.build     = 1'b1;
            S_SCAN:   cmd.scan_step = 1'b1;
            S_DRAIN:  ;
            S_REL_RD: cmd.rel_read  = 1'b1;
            S_COMMIT: cmd.commit    = sts.out_free;
            default:  ;
        endcase
    end

endmodule

### rtl/core/wplb_dpath.sv
module wplb_dpath #(
    parameter int MAX_WORKERS = wplb_pkg::MAX_WORKERS_DEF,
    parameter int LOAD_WIDTH  = wplb_pkg::LOAD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [wplb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wplb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [wplb_pkg::OP_W-1:0]           in_operation,
    input  logic [wplb_pkg::ID_W-1:0]           in_worker_id,
    input  wplb_pkg::cmd_t                      cmd,
    output wplb_pkg::sts_t                      sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [wplb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [wplb_pkg::STATUS_W-1:0]       m_tuser
);

    import wplb_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORKERS);
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

    // clip a load to the output field
    function automatic logic [OUT_LOAD_W-1:0] sat_load(input logic [LOAD_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        sat_load = (w > OUT_LOAD_MAX) ? '1 : w[OUT_LOAD_W-1:0];
    endfunction

    // configuration registers
    logic              mode_reg;
    logic [POOL_W-1:0] pool_size_reg;
    logic [CAP_W-1:0]  capacity_reg;

    // latched request
    logic [OP_W-1:0] op_reg;
    logic [ID_W-1:0] id_reg;

    // pool state
    logic [MAX_WORKERS-1:0] valid_reg, valid_next;
    logic [MAX_WORKERS-1:0] live_reg, live_next;
    logic                   pool_ready_reg, pool_ready_next;
    logic [CNT_W-1:0]       valid_cnt_reg, valid_cnt_next;

    // scan state
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic                  chk_vld_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [LOAD_WIDTH-1:0] best_load_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    // output register
    logic                  m_valid_reg;
    logic [ID_W-1:0]       out_worker_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [OUT_LOAD_W-1:0] out_load_reg;

    // ram interface
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [LOAD_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [LOAD_WIDTH-1:0] ram_q;

    // combinational helpers
    logic [CAP_W-1:0]      cap_eff;
    logic [31:0]           pool_sel;
    logic [CNT_W-1:0]      build_n;
    logic [LOAD_WIDTH-1:0] chk_load;
    logic                  chk_valid;
    logic                  chk_fits;
    logic                  take;
    logic                  take_free;
    logic [IDX_W-1:0]      rel_idx;
    logic                  rel_bad;
    logic [LOAD_WIDTH-1:0] rel_cur;
    logic [LOAD_WIDTH-1:0] rel_dec;
    logic                  rel_retire;
    logic [LOAD_WIDTH-1:0] bump_load;
    logic [ID_W-1:0]       res_worker;
    status_t               res_status;
    logic [OUT_LOAD_W-1:0] res_load;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_FIXED;
            pool_size_reg <= POOL_W'(DEFAULT_POOL);
            capacity_reg  <= CAP_W'(DEFAULT_CAPACITY);
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_POOL_SIZE: pool_size_reg <= cfg_data[POOL_W-1:0];
                REG_CAPACITY:  capacity_reg  <= cfg_data[CAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= in_operation;
            id_reg <= in_worker_id;
        end
    end

    // effective capacity and pool size
    always_comb begin
        cap_eff  = (capacity_reg == '0) ? CAP_W'(DEFAULT_CAPACITY) : capacity_reg;
        pool_sel = (pool_size_reg == '0) ? 32'(DEFAULT_POOL) : 32'(pool_size_reg);
        if (pool_sel > 32'(MAX_WORKERS)) begin
            pool_sel = 32'(MAX_WORKERS);
        end
        build_n = CNT_W'(pool_sel);
    end

    // scan compare on the beat coming back from the ram
    assign chk_load  = live_reg[chk_idx_reg] ? ram_q : '0;
    assign chk_valid = valid_reg[chk_idx_reg];
    assign chk_fits  = 32'(chk_load) < 32'(cap_eff);
    assign take      = chk_vld_reg && chk_valid &&
                       ((mode_reg == MODE_CAPACITY) ? (!found_reg && chk_fits)
                                                    : (!found_reg || chk_load < best_load_reg));
    assign take_free = chk_vld_reg && !chk_valid && !free_found_reg;

    // scan counter and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            chk_vld_reg <= cmd.scan_step;
            if (cmd.scan_init) begin
                scan_cnt_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
                if (take_free) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            chk_idx_reg <= scan_cnt_reg;
        end
        if (take) begin
            best_idx_reg  <= chk_idx_reg;
            best_load_reg <= chk_load;
        end
        if (take_free) begin
            free_idx_reg <= chk_idx_reg;
        end
    end

    // release lookup
    assign rel_idx    = IDX_W'(id_reg);
    assign rel_bad    = (32'(id_reg) >= 32'(MAX_WORKERS)) || !valid_reg[rel_idx];
    assign rel_cur    = live_reg[rel_idx] ? ram_q : '0;
    assign rel_dec    = (rel_cur != '0) ? rel_cur - LOAD_WIDTH'(1) : '0;
    assign rel_retire = (mode_reg == MODE_CAPACITY) && (rel_dec == '0) &&
                        (valid_cnt_reg >= CNT_W'(2));

    // acquire increment, saturating
    assign bump_load = (best_load_reg != LOAD_MAX) ? best_load_reg + LOAD_WIDTH'(1)
                                                   : best_load_reg;

    // ram read port
    assign rd_en   = cmd.scan_step | cmd.rel_read;
    assign rd_addr = cmd.scan_step ? scan_cnt_reg : rel_idx;

    // pool build and result commit
    always_comb begin
        valid_next      = valid_reg;
        live_next       = live_reg;
        pool_ready_next = pool_ready_reg;
        valid_cnt_next  = valid_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = bump_load;
        res_worker      = '0;
        res_status      = STS_CLEARED;
        res_load        = '0;

        if (cmd.build) begin
            pool_ready_next = 1'b1;
            if (mode_reg == MODE_FIXED) begin
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (i < int'(build_n)) begin
                        valid_next[i] = 1'b1;
                    end
                end
                valid_cnt_next = build_n;
            end else begin
                valid_next[0]  = 1'b1;
                valid_cnt_next = CNT_W'(1);
            end
        end

        if (cmd.commit) begin
            case (op_t'(op_reg))
                OP_ACQUIRE: begin
                    if (found_reg) begin
                        wr_en                   = 1'b1;
                        live_next[best_idx_reg] = 1'b1;
                        res_worker              = ID_W'(best_idx_reg);
                        res_status              = STS_GRANTED;
                        res_load                = sat_load(bump_load);
                    end else if (mode_reg == MODE_CAPACITY && free_found_reg) begin
                        // open a new worker in the lowest free slot
                        wr_en                   = 1'b1;
                        wr_addr                 = free_idx_reg;
                        wr_data                 = LOAD_WIDTH'(1);
                        valid_next[free_idx_reg] = 1'b1;
                        live_next[free_idx_reg]  = 1'b1;
                        valid_cnt_next          = valid_cnt_reg + CNT_W'(1);
                        res_worker              = ID_W'(free_idx_reg);
                        res_status              = STS_GRANTED;
                        res_load                = OUT_LOAD_W'(1);
                    end else begin
                        res_status = STS_FULL;
                    end
                end
                OP_RELEASE: begin
                    res_worker = id_reg;
                    if (rel_bad) begin
                        res_status = STS_INVALID;
                    end else begin
                        wr_en              = 1'b1;
                        wr_addr            = rel_idx;
                        wr_data            = rel_dec;
                        live_next[rel_idx] = 1'b1;
                        if (rel_retire) begin
                            valid_next[rel_idx] = 1'b0;
                            valid_cnt_next      = valid_cnt_reg - CNT_W'(1);
                            res_status          = STS_RETIRED;
                        end else begin
                            res_status = STS_RELEASED;
                            res_load   = sat_load(rel_dec);
                        end
                    end
                end
                OP_CLEAR: begin
                    live_next  = '0;
                    res_status = STS_CLEARED;
                end
                default: ;
            endcase
        end
    end

    // pool state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            live_reg       <= '0;
            pool_ready_reg <= 1'b0;
            valid_cnt_reg  <= '0;
        end else begin
            valid_reg      <= valid_next;
            live_reg       <= live_next;
            pool_ready_reg <= pool_ready_next;
            valid_cnt_reg  <= valid_cnt_next;
        end
    end

    // load counters
    wplb_ram #(
        .WIDTH(LOAD_WIDTH),
        .DEPTH(MAX_WORKERS)
    ) u_load_ram (
        .clk  (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    // output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_worker_reg <= res_worker;
            out_status_reg <= res_status;
            out_load_reg   <= res_load;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - ID_W - OUT_LOAD_W)'(0), out_load_reg, out_worker_reg};
    assign m_tuser  = out_status_reg;

    // status to controller
    assign sts.op         = op_reg;
    assign sts.rel_bad    = rel_bad;
    assign sts.pool_ready = pool_ready_reg;
    assign sts.scan_last  = (scan_cnt_reg == IDX_W'(MAX_WORKERS - 1));
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

### rtl/core/worker_pool_load_balancer.sv
// worker pool load balancer: hands out worker slots and keeps a load count per slot
// request beats on s_*: s_tuser carries the operation (acquire, release, clear),
// s_tdata carries the worker slot for a release
// one result beat per request on m_*: m_tuser carries the status, m_tdata the slot
// and its load after the operation; an unused operation code gives no result
// registers (mode, pool size, capacity) are written on the cfg port; the user must write
// them only while idle, since the block itself does not enforce it
// an acquire decodes, builds the pool if it is not yet built, scans every slot, drains
// the last read and commits; a release decodes, reads the load and commits, but skips the
// read for an unknown slot; a clear decodes and commits
// one request at a time; the controller returns to idle and takes the next request once
// the result is loaded; the scan reads one load counter per cycle through the single read
// port of the counter ram
// a result waiting on m_tready does not block the next request, but that
// request holds in its final step until the output register is free
// reset empties the pool, zeroes all loads and restores the register defaults
`include "worker_pool_load_balancer_assert.svh"

module worker_pool_load_balancer #(
    parameter int MAX_WORKERS = wplb_pkg::MAX_WORKERS_DEF,
    parameter int LOAD_WIDTH  = wplb_pkg::LOAD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wplb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wplb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wplb_pkg::S_TDATA_W-1:0]   s_tdata,   // [3:0] worker_id, [7:4] zero
    input  logic [wplb_pkg::OP_W-1:0]        s_tuser,   // [1:0] operation
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wplb_pkg::M_TDATA_W-1:0]   m_tdata,   // [3:0] granted_worker,
                                                        // [19:4] worker_load, [23:20] zero
    output logic [wplb_pkg::STATUS_W-1:0]    m_tuser    // [2:0] status
);

    import wplb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers always take a write
    assign cfg_ready = 1'b1;

    // controller
    wplb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath with load counter ram
    wplb_dpath #(
        .MAX_WORKERS(MAX_WORKERS),
        .LOAD_WIDTH (LOAD_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_operation(s_tuser),
        .in_worker_id(s_tdata[ID_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // one request in flight: no second beat right after one is taken
    `WPLB_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // a result is never loaded over one that is still stalled
    `WPLB_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, !cmd.commit, "result overwritten")

    // a granted worker always carries a nonzero load
    `WPLB_ASSERT_IMP(a_grant_load, m_tvalid && m_tuser == STS_GRANTED,
                     m_tdata[ID_W+OUT_LOAD_W-1:ID_W] != '0, "grant with zero load")

endmodule

### bench/worker_pool_load_balancer_checker.sv
module worker_pool_load_balancer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [wplb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wplb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [wplb_pkg::S_TDATA_W-1:0]  s_tdata,   // [3:0] worker_id, [7:4] zero
    input  logic [wplb_pkg::OP_W-1:0]       s_tuser,   // [1:0] operation
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wplb_pkg::M_TDATA_W-1:0]  m_tdata,   // [3:0] granted_worker, [19:4] worker_load
    input  logic [wplb_pkg::STATUS_W-1:0]   m_tuser,   // [2:0] status
    output int                              pending,
    output int                              mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import wplb_pkg::*;

    localparam int WORKERS   = MAX_WORKERS_DEF;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [ID_W-1:0]       worker;
        status_t               status;
        logic [OUT_LOAD_W-1:0] load;
    } grant_t;

    // shadow of the pool and the registers
    logic [LOAD_WIDTH_DEF-1:0] load_cnt [WORKERS];
    bit                        slot_live [WORKERS];
    bit                        pool_built;
    logic                      op_mode;
    logic [POOL_W-1:0]         pool_reg;
    logic [CAP_W-1:0]          cap_reg;

    grant_t expected_grants [$];

    task automatic flag_mismatch(input string field, input logic [31:0] got_val,
                                 input logic [31:0] exp_val);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] %s: got %0d expected %0d", $time, field, got_val, exp_val);
        mismatch_count++;
    endtask

    // work out the answer to one request beat and update the shadow pool
    task automatic predict_outcome(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        int               n;
        int               best;
        int               others;
        bit               found;
        logic [CAP_W-1:0] limit;
        grant_t           g;
        g      = '{worker: '0, status: STS_CLEARED, load: '0};
        found  = 1'b0;
        best   = 0;
        others = 0;
        case (op)
            OP_ACQUIRE: begin
                // first acquire builds the pool in whatever mode is live
                if (!pool_built) begin
                    pool_built = 1'b1;
                    if (op_mode == MODE_FIXED) begin
                        n = (pool_reg == 0) ? DEFAULT_POOL :
                            (pool_reg > WORKERS) ? WORKERS : int'(pool_reg);
                        for (int i = 0; i < n; i++) begin
                            slot_live[i] = 1'b1;
                            load_cnt[i]  = '0;
                        end
                    end else begin
                        slot_live[0] = 1'b1;
                        load_cnt[0]  = '0;
                    end
                end
                g.status = STS_FULL;
                if (op_mode == MODE_FIXED) begin
                    // least loaded, ties to the lowest slot
                    for (int i = 0; i < WORKERS; i++)
                        if (slot_live[i] && (!found || load_cnt[i] < load_cnt[best])) begin
                            best  = i;
                            found = 1'b1;
                        end
                end else begin
                    // first fit under capacity, else open the lowest free slot
                    limit = (cap_reg == 0) ? CAP_W'(DEFAULT_CAPACITY) : cap_reg;
                    for (int i = 0; i < WORKERS && !found; i++)
                        if (slot_live[i] && load_cnt[i] < limit) begin
                            best  = i;
                            found = 1'b1;
                        end
                    for (int i = 0; i < WORKERS && !found; i++)
                        if (!slot_live[i]) begin
                            slot_live[i] = 1'b1;
                            load_cnt[i]  = '0;
                            best         = i;
                            found        = 1'b1;
                        end
                end
                if (found) begin
                    if (load_cnt[best] != '1)
                        load_cnt[best]++;
                    g = '{worker: ID_W'(best), status: STS_GRANTED, load: load_cnt[best]};
                end
            end
            OP_RELEASE: begin
                g.worker = id;
                if (!slot_live[id]) begin
                    g.status = STS_INVALID;
                end else begin
                    if (load_cnt[id] != 0)
                        load_cnt[id]--;
                    for (int i = 0; i < WORKERS; i++)
                        if (i != int'(id) && slot_live[i])
                            others++;
                    // idle worker retires in capacity mode unless it is the last one
                    if (op_mode == MODE_CAPACITY && load_cnt[id] == 0 && others > 0) begin
                        slot_live[id] = 1'b0;
                        g.status      = STS_RETIRED;
                    end else begin
                        g.status = STS_RELEASED;
                        g.load   = load_cnt[id];
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < WORKERS; i++)
                    load_cnt[i] = '0;
            end
            default: return;  // unused code gives no result
        endcase
        expected_grants.push_back(g);
    endtask

    always @(posedge aclk) begin : monitor
        grant_t want;
        if (!aresetn) begin
            op_mode    = MODE_FIXED;
            pool_reg   = POOL_W'(DEFAULT_POOL);
            cap_reg    = CAP_W'(DEFAULT_CAPACITY);
            pool_built = 1'b0;
            for (int i = 0; i < WORKERS; i++) begin
                load_cnt[i]  = '0;
                slot_live[i] = 1'b0;
            end
            expected_grants.delete();
            mismatch_count = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_MODE:      op_mode  = cfg_data[0];
                    REG_POOL_SIZE: pool_reg = cfg_data[POOL_W-1:0];
                    REG_CAPACITY:  cap_reg  = cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    flag_mismatch("result beat with nothing pending", m_tuser, 0);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tdata[ID_W-1:0] !== want.worker)
                        flag_mismatch("granted_worker", m_tdata[ID_W-1:0], want.worker);
                    if (m_tuser !== want.status)
                        flag_mismatch("status", m_tuser, want.status);
                    if (m_tdata[ID_W +: OUT_LOAD_W] !== want.load)
                        flag_mismatch("worker_load", m_tdata[ID_W +: OUT_LOAD_W], want.load);
                end
            end
            // request beat
            if (s_tvalid && s_tready)
                predict_outcome(s_tuser, s_tdata[ID_W-1:0]);
        end
        pending = expected_grants.size();
    end

endmodule

### bench/worker_pool_load_balancer_test.sv
module worker_pool_load_balancer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wplb_pkg::*;

    localparam int              WORKERS       = MAX_WORKERS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int              SETTLE_CYCLES = 2 * WORKERS;
    localparam int              STALL_LIMIT   = 2000;
    localparam int              BATCH_ITEMS   = 72;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [3:0] worker_id, [7:4] zero
    logic [OP_W-1:0]       s_tuser;   // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [3:0] granted_worker, [19:4] worker_load, [23:20] zero
    logic [STATUS_W-1:0]   m_tuser;   // [2:0] status

    int pending;
    int mismatch_count;
    int gap_pct   = 25;
    int stall_pct = 20;

    worker_pool_load_balancer dut (.*);

    worker_pool_load_balancer_checker checker_i (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // request beat, entered and left at a falling edge; valid stays up on return
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-ID_W){1'b0}}, id};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // drain every pending result, let stray no-result requests finish, then write all registers
    task automatic configure(input logic mode, input logic [POOL_W-1:0] pool,
                             input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(REG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_register(REG_POOL_SIZE, {{(CFG_DATA_W-POOL_W){1'b0}}, pool});
        write_register(REG_CAPACITY, cap);
        cfg_valid <= 1'b0;
    endtask

    // random mix of requests; the unused code is noise and not counted
    task automatic random_batch(input int count, input int acq_pct, input int rel_pct);
        int              done;
        int              pick;
        logic [ID_W-1:0] id;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, WORKERS - 1));
            if (pick < acq_pct) begin
                send_request(OP_ACQUIRE, id);
                done++;
            end else if (pick < acq_pct + rel_pct) begin
                // lean toward low slots, where live workers tend to sit
                if ($urandom_range(0, 1))
                    id = ID_W'($urandom_range(0, $urandom_range(0, WORKERS - 1)));
                send_request(OP_RELEASE, id);
                done++;
            end else if (pick < 97) begin
                send_request(OP_CLEAR, id);
                done++;
            end else begin
                send_request(OP_UNUSED, id);
            end
        end
    endtask

    // result side back-pressure in random bursts
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // give up when no channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [POOL_W-1:0] build_size;
        logic              mode;
        logic [POOL_W-1:0] pool;
        logic [CAP_W-1:0]  cap;
        int                acq;
        int                rel;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ACQUIRE;
        aresetn   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // before the pool exists: clear, releases of unknown slots, unused code
        send_request(OP_CLEAR, 4'd0);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_UNUSED, 4'd9);

        // build a fixed pool, size possibly zero or oversized
        case ($urandom_range(0, 4))
            0:       build_size = 5'd0;
            1:       build_size = 5'd1;
            2:       build_size = 5'd16;
            3:       build_size = 5'd31;
            default: build_size = POOL_W'($urandom_range(2, 15));
        endcase
        configure(MODE_FIXED, build_size, 16'd0);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd0);
        // release slot 0 down past zero (not with a pool of one), then slot 15, unknown unless all 16 slots are built
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_ACQUIRE, 4'd5);
        send_request(OP_CLEAR, 4'd15);
        send_request(OP_ACQUIRE, 4'd10);

        // live switch to capacity mode with the smallest capacity: growth and retirement
        configure(MODE_CAPACITY, 5'd31, 16'd1);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd7);
        send_request(OP_RELEASE, 4'd1);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd2);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_ACQUIRE, 4'd8);
        send_request(OP_ACQUIRE, 4'd3);

        // random phases over several register settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin mode = MODE_CAPACITY; pool = 5'd31; cap = 16'd2;
                         acq = 80; rel = 15; end
                1: begin mode = MODE_FIXED; pool = 5'd1; cap = 16'hFFFF;
                         acq = 55; rel = 40; end
                2: begin mode = MODE_CAPACITY; pool = POOL_W'($urandom_range(0, 31));
                         cap = 16'hFFFF; acq = 60; rel = 35; end
                3: begin mode = MODE_CAPACITY; pool = 5'd16; cap = 16'd0;
                         acq = 45; rel = 50; end
                4: begin mode = MODE_FIXED; pool = 5'd0; cap = CAP_W'($urandom_range(1, 8));
                         acq = 60; rel = 35; end
                5: begin mode = MODE_CAPACITY; pool = 5'd7; cap = 16'd1;
                         acq = 80; rel = 16; end
                6: begin mode = MODE_CAPACITY; pool = POOL_W'($urandom_range(0, 31));
                         cap = CAP_W'($urandom_range(1, 4)); acq = 55; rel = 42; end
                default: begin mode = MODE_FIXED; pool = POOL_W'($urandom_range(0, 31));
                         cap = CAP_W'($urandom); acq = 60; rel = 36; end
            endcase
            // no idling in the last phases, some earlier phases without it too
            if (p >= 6) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
            end
            configure(mode, pool, cap);
            random_batch(BATCH_ITEMS, acq, rel);
        end

        // wait out the last results
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/wplb_pkg.sv
rtl/core/wplb_ram.sv
rtl/core/wplb_ctrl.sv
rtl/core/wplb_dpath.sv
rtl/core/worker_pool_load_balancer.sv
bench/worker_pool_load_balancer_checker.sv
bench/worker_pool_load_balancer_test.sv
